// ----- src/pcbs_pkg.sv -----
`default_nettype none
package pcbs_pkg;

	localparam int MaxSegments = 16;
	localparam int SegW = $clog2(MaxSegments);
	localparam int CntW = $clog2(MaxSegments + 1);
	localparam int CoordDepth = MaxSegments * 4;
	localparam int CoordAw = $clog2(CoordDepth);
	localparam logic [16:0] OneT = 17'h10000;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_POINT  = 2'd2,
		FUNC_SAMPLE = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZERO,
		ST_RD_FIRST,
		ST_CHK_FIRST,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DIV,
		ST_WEIGHT,
		ST_MAC_RD,
		ST_MAC,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Selects where the output register is loaded from.
	typedef enum logic [1:0] {
		OSEL_ZERO,
		OSEL_POINT,
		OSEL_SUM
	} osel_t;

	typedef struct packed {
		logic       clear_cnt;
		logic       append;
		logic       wr_point;
		logic       latch_in;
		logic       rd_time;
		logic [1:0] rd_sel;      // 0 first, 1 last, 2 scan index
		logic       rd_point;
		logic [1:0] rd_pidx;
		logic       pt_use_last;
		logic       scan_clr;
		logic       scan_inc;
		logic       div_start;
		logic       div_step;
		logic       weight_step;
		logic       mac_clr;
		logic       mac_acc;
		logic [1:0] mac_k;
		logic       out_load;
		osel_t      out_sel;
		logic       strobe;
	} ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic le_first;
		logic ge_last;
		logic scan_hit;
		logic scan_end;
		logic div_done;
		logic weight_done;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/pcbs_ctrl.sv -----
`default_nettype none
module pcbs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    func,
	input  wire pcbs_pkg::sts_t sts,
	output logic               busy,
	output pcbs_pkg::ctl_t     ctl
);
	import pcbs_pkg::*;

	state_t state_q, state_nx;
	logic [1:0] k_q;
	logic k_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= 2'd0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_WEIGHT) k_q <= 2'd0;
			else if (k_inc) k_q <= k_q + 2'd1;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_SAMPLE)
					state_nx = sts.empty ? ST_ZERO : ST_RD_FIRST;
			end
			ST_ZERO: state_nx = ST_DONE;
			ST_RD_FIRST: state_nx = ST_CHK_FIRST;
			ST_CHK_FIRST: state_nx = sts.le_first ? ST_DONE : ST_RD_LAST;
			ST_RD_LAST: state_nx = ST_CHK_LAST;
			ST_CHK_LAST: state_nx = sts.ge_last ? ST_DONE : ST_SCAN_RD;
			ST_SCAN_RD: state_nx = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (sts.scan_hit) state_nx = ST_DIV;
				else if (sts.scan_end) state_nx = ST_DONE;
				else state_nx = ST_SCAN_RD;
			end
			ST_DIV: if (sts.div_done) state_nx = ST_WEIGHT;
			ST_WEIGHT: if (sts.weight_done) state_nx = ST_MAC_RD;
			ST_MAC_RD: state_nx = ST_MAC;
			ST_MAC: state_nx = (k_q == 2'd3) ? ST_ROUND : ST_MAC_RD;
			ST_ROUND: state_nx = ST_DONE;
			ST_DONE: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.out_sel = OSEL_ZERO;
		k_inc = 1'b0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.latch_in = 1'b1;
					ctl.clear_cnt = (func == FUNC_CLEAR);
					ctl.append = (func == FUNC_APPEND) && !sts.full;
					ctl.wr_point = (func == FUNC_POINT) && !sts.empty;
				end
			end
			ST_ZERO: begin
				ctl.out_load = 1'b1;
				ctl.out_sel = OSEL_ZERO;
			end
			ST_RD_FIRST: begin
				ctl.rd_time = 1'b1;
				ctl.rd_sel = 2'd0;
				ctl.rd_point = 1'b1;
				ctl.rd_pidx = 2'd0;
			end
			ST_CHK_FIRST: begin
				ctl.out_load = sts.le_first;
				ctl.out_sel = OSEL_POINT;
			end
			ST_RD_LAST: begin
				ctl.rd_time = 1'b1;
				ctl.rd_sel = 2'd1;
				ctl.rd_point = 1'b1;
				ctl.rd_pidx = 2'd3;
				ctl.pt_use_last = 1'b1;
				ctl.scan_clr = 1'b1;
			end
			ST_CHK_LAST: begin
				ctl.out_load = 1'b1;
				ctl.out_sel = OSEL_POINT;
			end
			ST_SCAN_RD: begin
				ctl.rd_time = 1'b1;
				ctl.rd_sel = 2'd2;
			end
			ST_SCAN_CHK: begin
				ctl.scan_inc = !sts.scan_hit;
				ctl.div_start = sts.scan_hit;
			end
			ST_DIV: ctl.div_step = 1'b1;
			ST_WEIGHT: begin
				ctl.weight_step = 1'b1;
				ctl.mac_clr = 1'b1;
			end
			ST_MAC_RD: begin
				ctl.rd_point = 1'b1;
				ctl.rd_pidx = k_q;
			end
			ST_MAC: begin
				ctl.mac_acc = 1'b1;
				ctl.mac_k = k_q;
				k_inc = 1'b1;
			end
			ST_ROUND: begin
				ctl.out_load = 1'b1;
				ctl.out_sel = OSEL_SUM;
			end
			ST_DONE: ctl.strobe = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/pcbs_dp.sv -----
`default_nettype none
module pcbs_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pcbs_pkg::ctl_t       ctl,
	input  wire logic [31:0]          time_a,
	input  wire logic [31:0]          time_b,
	input  wire logic [1:0]           point_index,
	input  wire logic signed [31:0]   coord_x,
	input  wire logic signed [31:0]   coord_y,
	input  wire logic signed [31:0]   coord_z,
	output pcbs_pkg::sts_t            sts,
	output logic signed [31:0]        pos_x,
	output logic signed [31:0]        pos_y,
	output logic signed [31:0]        pos_z
);
	import pcbs_pkg::*;

	logic [CntW-1:0] cnt_q;
	logic [SegW-1:0] last_idx, scan_q, rd_idx, pt_seg;
	logic [31:0] t_q;

	logic [31:0] start_mem [MaxSegments];
	logic [31:0] end_mem [MaxSegments];
	logic [95:0] pt_mem [CoordDepth];
	logic [31:0] st_rd_q, en_rd_q;
	logic [95:0] pt_rd_q;
	logic [CoordAw-1:0] pt_wa, pt_ra;

	// Append zeroes the new segment's four points: done here with a
	// written flag per point row so each row reads zero until written.
	logic [CoordDepth-1:0] pt_wr_q;
	logic pt_rd_ok_q;

	assign last_idx = SegW'(cnt_q - CntW'(1));
	assign sts.empty = (cnt_q == '0);
	assign sts.full = (cnt_q == CntW'(MaxSegments));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pt_wr_q <= '0;
		end else begin
			if (ctl.clear_cnt) cnt_q <= '0;
			else if (ctl.append) begin
				cnt_q <= cnt_q + CntW'(1);
				for (int p = 0; p < 4; p++)
					pt_wr_q[{cnt_q[SegW-1:0], 2'(p)}] <= 1'b0;
			end
			if (ctl.wr_point) pt_wr_q[pt_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) t_q <= time_a;
		if (ctl.append) begin
			start_mem[cnt_q[SegW-1:0]] <= time_a;
			end_mem[cnt_q[SegW-1:0]] <= time_b;
		end
		if (ctl.rd_time) begin
			st_rd_q <= start_mem[rd_idx];
			en_rd_q <= end_mem[rd_idx];
		end
		if (ctl.wr_point) pt_mem[pt_wa] <= {coord_z, coord_y, coord_x};
		if (ctl.rd_point) begin
			pt_rd_q <= pt_mem[pt_ra];
			pt_rd_ok_q <= pt_wr_q[pt_ra];
		end
	end

	assign pt_wa = {last_idx, point_index};
	always_comb begin
		case (ctl.rd_sel)
			2'd0: rd_idx = '0;
			2'd1: rd_idx = last_idx;
			default: rd_idx = scan_q;
		endcase
	end
	assign pt_seg = ctl.pt_use_last ? last_idx : scan_q;
	assign pt_ra = {(ctl.rd_time && ctl.rd_pidx == 2'd0 && !ctl.pt_use_last &&
		ctl.rd_sel == 2'd0) ? {SegW{1'b0}} : pt_seg, ctl.rd_pidx};

	logic [95:0] pt_val;
	assign pt_val = pt_rd_ok_q ? pt_rd_q : 96'd0;

	assign sts.le_first = (t_q <= st_rd_q);
	assign sts.ge_last = (t_q >= en_rd_q);
	assign sts.scan_hit = !(t_q < st_rd_q || t_q > en_rd_q);
	assign sts.scan_end = (scan_q == last_idx);

	always_ff @(posedge clk) begin
		if (ctl.scan_clr) scan_q <= '0;
		else if (ctl.scan_inc) scan_q <= scan_q + SegW'(1);
	end

	// Restoring division, one quotient bit a cycle: (dt << 16) / span.
	logic [31:0] span_q;
	logic [47:0] num_q;
	logic [32:0] rem_q;
	logic [5:0] div_cnt_q;
	logic [16:0] t_clamp;
	logic [33:0] rem_sh, rem_sub;
	logic zero_span_q;

	assign rem_sh = {rem_q, num_q[47]};
	assign rem_sub = rem_sh - {2'b00, span_q};
	assign sts.div_done = (div_cnt_q == 6'd0);

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			span_q <= en_rd_q - st_rd_q;
			zero_span_q <= (en_rd_q == st_rd_q);
			num_q <= {t_q - st_rd_q, 16'd0};
			rem_q <= '0;
			div_cnt_q <= 6'd48;
		end else if (ctl.div_step && div_cnt_q != 6'd0) begin
			num_q <= {num_q[46:0], !rem_sub[33]};
			rem_q <= rem_sub[33] ? rem_sh[32:0] : rem_sub[32:0];
			div_cnt_q <= div_cnt_q - 6'd1;
		end
	end

	// Quotient < 2^17 if dt <= span; clamp to one, zero span to zero.
	always_comb begin
		if (zero_span_q) t_clamp = '0;
		else if (num_q[47:17] != '0 || num_q[16:0] > OneT) t_clamp = OneT;
		else t_clamp = num_q[16:0];
	end

	// Weights over a few steps, at most two variable multiplies per cycle.
	logic [2:0] wstep_q;
	logic [16:0] tt_q, mt_q;
	logic [33:0] t2_q, m2_q;
	logic [32:0] w_q [4];
	logic [50:0] prod;
	logic [16:0] mul_a;
	logic [33:0] mul_b;

	assign sts.weight_done = (wstep_q == 3'd5);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (wstep_q)
			3'd1: begin mul_a = tt_q; mul_b = {17'd0, tt_q}; end
			3'd2: begin mul_a = mt_q; mul_b = {17'd0, mt_q}; end
			3'd3: begin mul_a = mt_q; mul_b = t2_q; end
			3'd4: begin mul_a = tt_q; mul_b = m2_q; end
			default: begin mul_a = mt_q; mul_b = {17'd0, tt_q}; end
		endcase
	end
	assign prod = 51'(mul_a) * 51'(mul_b);

	always_ff @(posedge clk) begin
		if (!ctl.weight_step) begin
			wstep_q <= 3'd0;
		end else begin
			wstep_q <= wstep_q + 3'd1;
			case (wstep_q)
				3'd0: begin
					tt_q <= t_clamp;
					mt_q <= OneT - t_clamp;
				end
				3'd1: t2_q <= prod[33:0];
				3'd2: begin
					m2_q <= prod[33:0];
					w_q[3] <= 33'(((51'(tt_q) * 51'(t2_q)) >> 16));
				end
				3'd3: begin
					w_q[2] <= 33'((51'(3) * prod) >> 16);
					w_q[0] <= 33'(((51'(mt_q) * 51'(m2_q)) >> 16));
				end
				3'd4: w_q[1] <= 33'((51'(3) * prod) >> 16);
				default: ;
			endcase
		end
	end

	// Per-point multiply-accumulate, three axes in parallel.
	logic signed [65:0] acc_q [3];
	logic signed [65:0] acc_rnd [3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (ctl.mac_clr) acc_q[a] <= '0;
			else if (ctl.mac_acc)
				acc_q[a] <= acc_q[a] + 66'(signed'({1'b0, w_q[ctl.mac_k]}) *
					66'(signed'(pt_val[a*32 +: 32])));
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++)
			acc_rnd[a] = acc_q[a] + 66'sh80000000;
	end

	logic [95:0] out_q;
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			case (ctl.out_sel)
				OSEL_POINT: out_q <= pt_val;
				OSEL_SUM: out_q <= {acc_rnd[2][63:32], acc_rnd[1][63:32],
					acc_rnd[0][63:32]};
				default: out_q <= '0;
			endcase
		end
	end

	assign pos_x = out_q[31:0];
	assign pos_y = out_q[63:32];
	assign pos_z = out_q[95:64];
endmodule
`default_nettype wire

// ----- src/piecewise_cubic_bezier_sampler.sv -----
// Piecewise cubic Bezier sampler.
// Issue a command by raising start with func and its operands while busy
// is low; the command is taken at that edge. Clear, append and point
// writes finish at that edge. A sample command raises busy and then
// presents pos_x/y/z for exactly one cycle with valid high. An empty
// table gives zero; a time at or before the first start gives the first
// segment's first point, and a time at or past the last end gives the last
// segment's last point. Otherwise the segments are scanned from the first;
// a time in a gap also gives that last point, and in the segment that holds
// it a restoring divider finds the parameter, the four weights are formed,
// the four points are accumulated with them and the sum is rounded.
// One sample is in flight at a time.
// The receiver cannot stall: a result is taken in the cycle it shows.
// Reset empties the segment table; stored times and points are not
// cleared, and a point reads as zero until it is written after append.
`default_nettype none
module piecewise_cubic_bezier_sampler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         func,
	input  wire logic [31:0]        time_a,
	input  wire logic [31:0]        time_b,
	input  wire logic [1:0]         point_index,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	output logic                    valid,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z
);
	import pcbs_pkg::*;

	ctl_t ctl;
	sts_t sts;

	pcbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.sts(sts), .busy(busy), .ctl(ctl)
	);

	pcbs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .time_a(time_a),
		.time_b(time_b), .point_index(point_index), .coord_x(coord_x),
		.coord_y(coord_y), .coord_z(coord_z), .sts(sts),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
	);

	assign valid = ctl.strobe;
endmodule
`default_nettype wire
